// ===== design/assert_macros.svh =====
// Assertion macros shared by the gated trigger sample qualifier RTL.
// Clocked on clk; GTSQ_ASSERT is quiet while rst is high, GTSQ_ASSERT_ALWAYS is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk outside reset.
`define GTSQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("gtsq assertion failed");

// Check a property at every rising edge of clk, reset included.
`define GTSQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("gtsq assertion failed");

`endif

// ===== design/gtsq_pkg.sv =====
// Shared types and constants for the gated trigger sample qualifier.
// Used by gtsq_cfg, gtsq_core and the top level.
package gtsq_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF  = 17;
  localparam int AVG_WIDTH        = 16;
  localparam int PADDR_WIDTH      = 4;
  localparam int PDATA_WIDTH      = 32;

  typedef enum logic [1:0] {
    REG_ACQUIRE  = 2'd0,
    REG_MODE     = 2'd1,
    REG_POLARITY = 2'd2,
    REG_AVERAGE  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_FREE    = 2'd0,
    MODE_TRIGGER = 2'd1,
    MODE_BULB    = 2'd2,
    MODE_GATE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    LEVEL_LOW     = 2'd0,
    LEVEL_HIGH    = 2'd1,
    LEVEL_UNKNOWN = 2'd2
  } level_t;

  typedef enum logic {
    OP_GATE   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic {
    KIND_SAMPLE   = 1'b0,
    KIND_BULB_END = 1'b1
  } kind_t;

  typedef struct packed {
    logic                 acquire_enable;
    mode_t                trigger_mode;
    logic                 trigger_polarity;
    logic [AVG_WIDTH-1:0] num_average;
    logic                 restart;
  } cfg_t;

  typedef struct packed {
    logic  emit;
    kind_t kind;
  } verdict_t;

endpackage

// ===== design/gtsq_cfg.sv =====
// Configuration register file behind the APB-style port.
// Depends on gtsq_pkg for register indexes and the cfg_t bundle.
module gtsq_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gtsq_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [gtsq_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [gtsq_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                              pready,
  output gtsq_pkg::cfg_t                    cfg
);

  logic                           acquire_enable;
  gtsq_pkg::mode_t                trigger_mode;
  logic                           trigger_polarity;
  logic [gtsq_pkg::AVG_WIDTH-1:0] num_average;
  logic                           restart;
  logic                           wr;
  gtsq_pkg::reg_idx_t             idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = gtsq_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      acquire_enable   <= 1'b0;
      trigger_mode     <= gtsq_pkg::MODE_FREE;
      trigger_polarity <= 1'b0;
      num_average      <= gtsq_pkg::AVG_WIDTH'(1);
      restart          <= 1'b0;
    end else begin
      restart <= 1'b0;
      if (wr) begin
        unique case (idx)
          gtsq_pkg::REG_ACQUIRE: begin
            restart        <= pwdata[0] && !acquire_enable;
            acquire_enable <= pwdata[0];
          end
          gtsq_pkg::REG_MODE:     trigger_mode     <= gtsq_pkg::mode_t'(pwdata[1:0]);
          gtsq_pkg::REG_POLARITY: trigger_polarity <= pwdata[0];
          gtsq_pkg::REG_AVERAGE:  num_average      <= pwdata[gtsq_pkg::AVG_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      gtsq_pkg::REG_ACQUIRE:  prdata[0]   = acquire_enable;
      gtsq_pkg::REG_MODE:     prdata[1:0] = trigger_mode;
      gtsq_pkg::REG_POLARITY: prdata[0]   = trigger_polarity;
      gtsq_pkg::REG_AVERAGE:  prdata[gtsq_pkg::AVG_WIDTH-1:0] = num_average;
      default: ;
    endcase
  end

  assign cfg = '{acquire_enable:   acquire_enable,
                 trigger_mode:     trigger_mode,
                 trigger_polarity: trigger_polarity,
                 num_average:      num_average,
                 restart:          restart};

endmodule

// ===== design/gtsq_core.sv =====
// Gate level, arm flag and capture counter with the per-item pass/drop decision.
// Depends on gtsq_pkg for modes, levels and the cfg_t/verdict_t bundles.
module gtsq_core #(
  parameter int COUNT_WIDTH = gtsq_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  gtsq_pkg::cfg_t    cfg,
  input  logic              item_valid,
  input  logic              advance,
  input  gtsq_pkg::op_t     item_op,
  input  logic              item_gate,
  output gtsq_pkg::verdict_t verdict
);

  localparam int CMP_W = (COUNT_WIDTH > gtsq_pkg::AVG_WIDTH) ? COUNT_WIDTH
                                                              : gtsq_pkg::AVG_WIDTH;

  gtsq_pkg::level_t         gate_level, gate_level_next;
  logic                     capture_armed, capture_armed_next;
  logic [COUNT_WIDTH-1:0]   captured_count, captured_count_next;
  logic [COUNT_WIDTH-1:0]   count_inc;
  gtsq_pkg::level_t         act_level, inact_level, new_level;
  logic                     live;

  assign act_level   = cfg.trigger_polarity ? gtsq_pkg::LEVEL_LOW  : gtsq_pkg::LEVEL_HIGH;
  assign inact_level = cfg.trigger_polarity ? gtsq_pkg::LEVEL_HIGH : gtsq_pkg::LEVEL_LOW;
  assign new_level   = item_gate ? gtsq_pkg::LEVEL_HIGH : gtsq_pkg::LEVEL_LOW;
  assign count_inc   = (&captured_count) ? captured_count : captured_count + 1'b1;
  assign live        = item_valid && cfg.acquire_enable;

  always_comb begin
    gate_level_next     = gate_level;
    capture_armed_next  = capture_armed;
    captured_count_next = captured_count;
    verdict             = '{emit: 1'b0, kind: gtsq_pkg::KIND_SAMPLE};
    if (live) begin
      unique case (item_op)
        gtsq_pkg::OP_GATE: begin
          gate_level_next = new_level;
          if (cfg.trigger_mode == gtsq_pkg::MODE_TRIGGER && new_level == act_level) begin
            capture_armed_next  = 1'b1;
            captured_count_next = '0;
          end
          if (cfg.trigger_mode == gtsq_pkg::MODE_BULB && new_level == inact_level) begin
            verdict = '{emit: 1'b1, kind: gtsq_pkg::KIND_BULB_END};
          end
        end
        gtsq_pkg::OP_SAMPLE: begin
          verdict.emit = 1'b1;
          unique case (cfg.trigger_mode)
            gtsq_pkg::MODE_TRIGGER: begin
              if (!capture_armed) begin
                verdict.emit = 1'b0;
              end else begin
                captured_count_next = count_inc;
                if (CMP_W'(count_inc) > CMP_W'(cfg.num_average)) begin
                  capture_armed_next = 1'b0;
                  verdict.emit       = 1'b0;
                end
              end
            end
            gtsq_pkg::MODE_BULB,
            gtsq_pkg::MODE_GATE: begin
              if (gate_level == inact_level) verdict.emit = 1'b0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      gate_level     <= gtsq_pkg::LEVEL_UNKNOWN;
      capture_armed  <= 1'b0;
      captured_count <= '0;
    end else if (advance) begin
      gate_level     <= gate_level_next;
      capture_armed  <= capture_armed_next;
      captured_count <= captured_count_next;
    end
  end

endmodule

// ===== design/gated_trigger_sample_qualifier.sv =====
// Gated trigger sample qualifier: input register, decision core, result register.
// Depends on gtsq_pkg, gtsq_cfg, gtsq_core and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) carries gate events (operation 0, gate_value)
//   and four-channel current samples (operation 1, current_a..current_d).
//   Output channel (out_valid/out_stall) carries forwarded samples (result_kind 0)
//   and bulb exposure-end markers (result_kind 1, all currents zero).
//   Each input item gives zero or one result.
//   Path: an item is held in the input register, the core decides on it
//   combinationally, and its result is loaded into the result register.
//   Throughput: one item per cycle unless out_stall holds; the gate/arm/count
//   state updates as the item leaves the input register; items go back to back.
//   Stall: out_stall holds the result register; the input register then holds
//   and in_stall rises only while it is full, so one item is absorbed.
//   Reset: channels empty, acquisition off, free-run mode, polarity active high,
//   num_average 1, gate level unknown, capture disarmed.
//   Configure over the APB-style port only while the block is idle. Enabling
//   acquisition restarts the gate level, arm flag and count.
`include "assert_macros.svh"

module gated_trigger_sample_qualifier #(
  parameter int SAMPLE_WIDTH = gtsq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = gtsq_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gtsq_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [gtsq_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [gtsq_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              operation,
  input  logic                              gate_value,
  input  logic signed [SAMPLE_WIDTH-1:0]    current_a,
  input  logic signed [SAMPLE_WIDTH-1:0]    current_b,
  input  logic signed [SAMPLE_WIDTH-1:0]    current_c,
  input  logic signed [SAMPLE_WIDTH-1:0]    current_d,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              result_kind,
  output logic signed [SAMPLE_WIDTH-1:0]    out_a,
  output logic signed [SAMPLE_WIDTH-1:0]    out_b,
  output logic signed [SAMPLE_WIDTH-1:0]    out_c,
  output logic signed [SAMPLE_WIDTH-1:0]    out_d
);

  gtsq_pkg::cfg_t           cfg;
  gtsq_pkg::verdict_t       verdict;
  logic                     s1_valid;
  gtsq_pkg::op_t            s1_op;
  logic                     s1_gate;
  logic [SAMPLE_WIDTH-1:0]  s1_a, s1_b, s1_c, s1_d;
  logic                     advance;
  logic                     take;
  logic                     bulb_end;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign take     = in_valid && !in_stall;

  gtsq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gtsq_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (s1_valid),
    .advance    (advance),
    .item_op    (s1_op),
    .item_gate  (s1_gate),
    .verdict    (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_op   <= gtsq_pkg::op_t'(operation);
      s1_gate <= gate_value;
      s1_a    <= current_a;
      s1_b    <= current_b;
      s1_c    <= current_c;
      s1_d    <= current_d;
    end
  end

  assign bulb_end = (verdict.kind == gtsq_pkg::KIND_BULB_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= verdict.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && verdict.emit) begin
      result_kind <= verdict.kind;
      out_a       <= bulb_end ? '0 : s1_a;
      out_b       <= bulb_end ? '0 : s1_b;
      out_c       <= bulb_end ? '0 : s1_c;
      out_d       <= bulb_end ? '0 : s1_d;
    end
  end

  `GTSQ_ASSERT(a_s1_holds_when_blocked, s1_valid && !advance |=> s1_valid)
  `GTSQ_ASSERT(a_bulb_end_zero, out_valid && result_kind |-> out_a == '0 && out_d == '0)
  `GTSQ_ASSERT(a_result_needs_acquire, $rose(out_valid) |-> $past(cfg.acquire_enable))
  `GTSQ_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid && !s1_valid)

endmodule

// ===== sim/gated_trigger_sample_qualifier_tb.sv =====
// Self-checking testbench for gated_trigger_sample_qualifier: directed and random item
// streams under random gaps and stalls, checked by a scoreboard with its own predictor.
// Depends on gtsq_pkg and the gated_trigger_sample_qualifier RTL.
module gated_trigger_sample_qualifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES  = 64;
  localparam int SETTLE       = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [31:0] CUR_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] CUR_MIN = 32'h8000_0000;

  typedef struct packed {
    gtsq_pkg::kind_t kind;
    logic [31:0]     a;
    logic [31:0]     b;
    logic [31:0]     c;
    logic [31:0]     d;
  } result_rec_t;

  class gate_qualifier_scoreboard;
    logic                                 acquire_on;
    gtsq_pkg::mode_t                      mode;
    logic                                 active_low;
    logic [gtsq_pkg::AVG_WIDTH-1:0]       avg_limit;
    gtsq_pkg::level_t                     level;
    logic                                 armed;
    logic [gtsq_pkg::COUNT_WIDTH_DEF-1:0] taken;
    result_rec_t                          awaited[$];
    int                                   mismatches;
    int                                   results_seen;
    int                                   bulb_ends;

    function new();
      acquire_on   = 1'b0;
      mode         = gtsq_pkg::MODE_FREE;
      active_low   = 1'b0;
      avg_limit    = gtsq_pkg::AVG_WIDTH'(1);
      mismatches   = 0;
      results_seen = 0;
      bulb_ends    = 0;
      restart_capture();
    endfunction

    function void restart_capture();
      level = gtsq_pkg::LEVEL_UNKNOWN;
      armed = 1'b0;
      taken = '0;
    endfunction

    function void set_register(gtsq_pkg::reg_idx_t idx, logic [31:0] value);
      case (idx)
        gtsq_pkg::REG_ACQUIRE: begin
          if (value[0] != acquire_on) begin
            if (value[0]) restart_capture();
            acquire_on = value[0];
          end
        end
        gtsq_pkg::REG_MODE:     mode = gtsq_pkg::mode_t'(value[1:0]);
        gtsq_pkg::REG_POLARITY: active_low = value[0];
        gtsq_pkg::REG_AVERAGE:  avg_limit = value[gtsq_pkg::AVG_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function void note_transfer(gtsq_pkg::op_t op, logic gate, logic [31:0] a,
                                logic [31:0] b, logic [31:0] c, logic [31:0] d);
      gtsq_pkg::level_t gate_active;
      gtsq_pkg::level_t gate_idle;
      result_rec_t      rec;
      if (!acquire_on) return;
      gate_active = active_low ? gtsq_pkg::LEVEL_LOW : gtsq_pkg::LEVEL_HIGH;
      gate_idle   = active_low ? gtsq_pkg::LEVEL_HIGH : gtsq_pkg::LEVEL_LOW;
      if (op == gtsq_pkg::OP_GATE) begin
        level = gate ? gtsq_pkg::LEVEL_HIGH : gtsq_pkg::LEVEL_LOW;
        if (mode == gtsq_pkg::MODE_TRIGGER && level == gate_active) begin
          armed = 1'b1;
          taken = '0;
        end else if (mode == gtsq_pkg::MODE_BULB && level == gate_idle) begin
          rec.kind = gtsq_pkg::KIND_BULB_END;
          rec.a = '0;
          rec.b = '0;
          rec.c = '0;
          rec.d = '0;
          awaited.insert(awaited.size(), rec);
        end
        return;
      end
      if (mode == gtsq_pkg::MODE_TRIGGER) begin
        if (!armed) return;
        if (taken != '1) taken = taken + 1'b1;
        if (taken > avg_limit) begin
          armed = 1'b0;
          return;
        end
      end
      if ((mode == gtsq_pkg::MODE_GATE || mode == gtsq_pkg::MODE_BULB) &&
          level == gate_idle) return;
      rec.kind = gtsq_pkg::KIND_SAMPLE;
      rec.a = a;
      rec.b = b;
      rec.c = c;
      rec.d = d;
      awaited.insert(awaited.size(), rec);
    endfunction

    function void check_result(gtsq_pkg::kind_t kind, logic [31:0] a, logic [31:0] b,
                               logic [31:0] c, logic [31:0] d);
      result_rec_t want;
      results_seen++;
      if (kind == gtsq_pkg::KIND_BULB_END) bulb_ends++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result kind=%0d a=%0d b=%0d c=%0d d=%0d", $time,
                   kind, $signed(a), $signed(b), $signed(c), $signed(d));
        return;
      end
      want = awaited[0];
      awaited.delete(0);
      if (kind !== want.kind || a !== want.a || b !== want.b || c !== want.c ||
          d !== want.d) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: expected kind=%0d a=%0d b=%0d c=%0d d=%0d", $time, want.kind,
                   $signed(want.a), $signed(want.b), $signed(want.c), $signed(want.d));
          $display("%0t: actual   kind=%0d a=%0d b=%0d c=%0d d=%0d", $time, kind,
                   $signed(a), $signed(b), $signed(c), $signed(d));
        end
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [gtsq_pkg::PADDR_WIDTH-1:0] paddr;
  logic [gtsq_pkg::PDATA_WIDTH-1:0] pwdata;
  logic [gtsq_pkg::PDATA_WIDTH-1:0] prdata;
  logic                             pready;
  logic                             in_valid;
  logic                             in_stall;
  logic                             operation;
  logic                             gate_value;
  logic signed [31:0]               current_a;
  logic signed [31:0]               current_b;
  logic signed [31:0]               current_c;
  logic signed [31:0]               current_d;
  logic                             out_valid;
  logic                             out_stall;
  logic                             result_kind;
  logic signed [31:0]               out_a;
  logic signed [31:0]               out_b;
  logic signed [31:0]               out_c;
  logic signed [31:0]               out_d;

  gate_qualifier_scoreboard board = new();

  logic sender_quiet;
  logic receiver_quiet;
  logic hold_request;
  int   quiet_cycles;
  int   input_transfers;
  int   phases_run;

  gated_trigger_sample_qualifier dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        board.note_transfer(gtsq_pkg::op_t'(operation), gate_value, current_a, current_b,
                            current_c, current_d);
        input_transfers++;
      end
      if (out_valid && !out_stall)
        board.check_result(gtsq_pkg::kind_t'(result_kind), out_a, out_b, out_c, out_d);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int wait_cycles;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      wait_cycles = receiver_quiet ? 0 : $urandom_range(0, 8);
      if (hold_request) begin
        wait_cycles = wait_cycles + HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_stall = 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic write_register(gtsq_pkg::reg_idx_t idx, logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.set_register(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic offer_item(gtsq_pkg::op_t op, logic gate, logic [31:0] a,
                            logic [31:0] b, logic [31:0] c, logic [31:0] d);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation  = op;
    gate_value = gate;
    current_a  = a;
    current_b  = b;
    current_c  = c;
    current_d  = d;
    in_valid   = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] draw_current();
    case ($urandom_range(0, 9))
      0: return CUR_MAX;
      1: return CUR_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer_random(int gate_pct);
    gtsq_pkg::op_t op;
    op = ($urandom_range(0, 99) < gate_pct) ? gtsq_pkg::OP_GATE : gtsq_pkg::OP_SAMPLE;
    offer_item(op, 1'($urandom_range(0, 1)), draw_current(), draw_current(),
               draw_current(), draw_current());
  endtask

  initial begin
    int              sent_items;
    int              count;
    int              gate_pct;
    int              pick;
    int              acq_action;
    gtsq_pkg::mode_t mode;
    logic            polarity;
    logic [15:0]     average;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    operation = gtsq_pkg::OP_SAMPLE;
    gate_value = 1'b0;
    current_a = '0;
    current_b = '0;
    current_c = '0;
    current_d = '0;
    sender_quiet = 1'b0;
    receiver_quiet = 1'b0;
    hold_request = 1'b0;
    quiet_cycles = 0;
    input_transfers = 0;
    phases_run = 0;
    sent_items = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    offer_item(gtsq_pkg::OP_SAMPLE, 1'b0, CUR_MAX, CUR_MIN, '0, '1);
    offer_item(gtsq_pkg::OP_GATE, 1'b1, '0, '0, '0, '0);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b1, 32'd5, 32'd6, 32'd7, 32'd8);
    drain();

    write_register(gtsq_pkg::REG_ACQUIRE, 32'd1);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b0, CUR_MAX, CUR_MIN, '0, '1);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b1, CUR_MIN, CUR_MAX, '1, '0);
    offer_item(gtsq_pkg::OP_GATE, 1'b0, '0, '0, '0, '0);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b0, 32'd1, 32'd2, 32'd3, 32'd4);
    offer_item(gtsq_pkg::OP_GATE, 1'b1, '0, '0, '0, '0);
    drain();

    write_register(gtsq_pkg::REG_MODE, 32'(gtsq_pkg::MODE_TRIGGER));
    write_register(gtsq_pkg::REG_AVERAGE, 32'd0);
    offer_item(gtsq_pkg::OP_GATE, 1'b1, '0, '0, '0, '0);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b0, 32'd11, 32'd12, 32'd13, 32'd14);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b0, 32'd15, 32'd16, 32'd17, 32'd18);
    drain();

    write_register(gtsq_pkg::REG_AVERAGE, 32'd1);
    offer_item(gtsq_pkg::OP_GATE, 1'b0, '0, '0, '0, '0);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b0, 32'd21, 32'd22, 32'd23, 32'd24);
    offer_item(gtsq_pkg::OP_GATE, 1'b1, '0, '0, '0, '0);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b0, 32'd25, 32'd26, 32'd27, 32'd28);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b0, 32'd29, 32'd30, 32'd31, 32'd32);
    drain();

    write_register(gtsq_pkg::REG_ACQUIRE, 32'd0);
    write_register(gtsq_pkg::REG_ACQUIRE, 32'd1);
    write_register(gtsq_pkg::REG_MODE, 32'(gtsq_pkg::MODE_BULB));
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b0, 32'd41, 32'd42, 32'd43, 32'd44);
    offer_item(gtsq_pkg::OP_GATE, 1'b0, CUR_MAX, CUR_MAX, CUR_MAX, CUR_MAX);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b1, 32'd45, 32'd46, 32'd47, 32'd48);
    offer_item(gtsq_pkg::OP_GATE, 1'b1, '0, '0, '0, '0);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b0, 32'd49, 32'd50, 32'd51, 32'd52);
    drain();

    write_register(gtsq_pkg::REG_ACQUIRE, 32'd0);
    write_register(gtsq_pkg::REG_ACQUIRE, 32'd1);
    write_register(gtsq_pkg::REG_MODE, 32'(gtsq_pkg::MODE_GATE));
    write_register(gtsq_pkg::REG_POLARITY, 32'd1);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b0, 32'd61, 32'd62, 32'd63, 32'd64);
    offer_item(gtsq_pkg::OP_GATE, 1'b1, '0, '0, '0, '0);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b0, 32'd65, 32'd66, 32'd67, 32'd68);
    offer_item(gtsq_pkg::OP_GATE, 1'b0, '0, '0, '0, '0);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b1, 32'd69, 32'd70, 32'd71, 32'd72);
    drain();

    write_register(gtsq_pkg::REG_ACQUIRE, 32'd1);
    offer_item(gtsq_pkg::OP_SAMPLE, 1'b0, 32'd81, 32'd82, 32'd83, 32'd84);

    for (int phase = 0; sent_items < RANDOM_ITEMS; phase++) begin
      drain();
      acq_action = 0;
      if (phase < 8) begin
        mode     = gtsq_pkg::mode_t'(phase % 4);
        polarity = 1'((phase / 4) % 2);
        average  = (phase == 1) ? 16'hFFFF : (phase == 5) ? 16'd0 :
                   16'($urandom_range(1, 6));
        if (phase == 3) acq_action = 1;
      end else begin
        mode     = gtsq_pkg::mode_t'($urandom_range(0, 3));
        polarity = 1'($urandom_range(0, 1));
        pick     = $urandom_range(0, 99);
        average  = (pick < 10) ? 16'd0 : (pick < 15) ? 16'hFFFF :
                   (pick < 20) ? 16'($urandom) : 16'($urandom_range(1, 8));
        pick       = $urandom_range(0, 9);
        acq_action = (pick == 0) ? 2 : (pick < 3) ? 1 : 0;
      end
      write_register(gtsq_pkg::REG_MODE, 32'(mode));
      write_register(gtsq_pkg::REG_POLARITY, 32'(polarity));
      write_register(gtsq_pkg::REG_AVERAGE, 32'(average));
      if (acq_action == 1) write_register(gtsq_pkg::REG_ACQUIRE, 32'd0);
      write_register(gtsq_pkg::REG_ACQUIRE, (acq_action == 2) ? 32'd0 : 32'd1);

      sender_quiet   = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      if (phase == 0) begin
        hold_request = 1'b1;
        sender_quiet = 1'b1;
      end
      case (mode)
        gtsq_pkg::MODE_FREE:    gate_pct = 15;
        gtsq_pkg::MODE_TRIGGER: gate_pct = 20;
        default:                gate_pct = 30;
      endcase
      count = (acq_action == 2) ? 10 : $urandom_range(40, 80);
      repeat (count) begin
        offer_random(gate_pct);
        if (acq_action != 2) sent_items++;
      end
      phases_run++;
    end

    drain();
    board.mismatches += board.awaited.size();
    $display("Covered %0d input transfers over %0d random phases plus a directed pass,",
             input_transfers, phases_run);
    $display("all trigger modes and polarities; %0d results checked, %0d bulb end markers.",
             board.results_seen, board.bulb_ends);
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
